@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/fcs_pkg.sv @@
// Shared constants and types of the centered FIR convolution block.
package fcs_pkg;

	localparam int MAX_TAPS_DEF    = 63;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEF_BITS_DEF   = 18;

	localparam int TAP_IDX_W    = 6;
	localparam int TAP_COUNT_W  = 6;
	localparam int SCALE_W      = 16;
	localparam int SCALE_FRAC_W = 8;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;

	// The scaler has three register stages from accumulator to result.
	localparam int SCALE_LAT = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 1'd1;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 6'd31;
	localparam logic [SCALE_W-1:0]     SCALE_RST     = 16'd256;

	typedef struct packed {
		logic push;
		logic clear;
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

@@ hdl/fcs_if.sv @@
// Handshake interfaces for the item, result and configuration channels.
interface fcs_item_if #(
	parameter int SAMPLE_BITS = fcs_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = fcs_pkg::COEF_BITS_DEF
);
	import fcs_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [TAP_IDX_W-1:0]         tap_index;
	logic signed [COEF_BITS-1:0]  tap_value;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                         last;

	modport source (output valid, action, tap_index, tap_value, sample, last, input ready);
	modport sink (input valid, action, tap_index, tap_value, sample, last, output ready);
endinterface

interface fcs_result_if #(
	parameter int SAMPLE_BITS = fcs_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] result;
	logic                          result_last;
	logic                          saturated;

	modport source (output valid, result, result_last, saturated, input ready);
	modport sink (input valid, result, result_last, saturated, output ready);
endinterface

interface fcs_cfg_if;
	import fcs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/centered_fir_convolution_scaled.sv @@
// Centered FIR correlation with gain: cell chain, sequencer and output register.
// A load transaction writes its tap while the block is idle. A result follows its sample through
// the feed load, the feed alignment shift, the partial-sum ripple through the cell chain and
// the scaler; each flushed result first pushes one zero sample into the window.
// One item is in work at a time; the output register lets the next item enter early.
// Reset sets tap_count to 31, scale to 1.0, and clears taps, window and counters at once.
`include "assert_macros.svh"

module centered_fir_convolution_scaled #(
	parameter int MAX_TAPS    = fcs_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = fcs_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = fcs_pkg::COEF_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fcs_item_if.sink      items,
	fcs_result_if.source  results,
	fcs_cfg_if.sink       cfg
);
	import fcs_pkg::*;

	localparam int TW       = $clog2(MAX_TAPS + 1);
	localparam int CW       = $clog2(MAX_TAPS);
	localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + $clog2(MAX_TAPS);
	localparam int LASTC    = MAX_TAPS - 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PUSHZ = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_SUM   = 3'd4;
	localparam logic [2:0] ST_SCALE = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]             state_q;
	logic [CW-1:0]          cnt_q;
	logic [TW-1:0]          pending_q;
	logic [TW-1:0]          flush_q;
	logic                   last_q;
	logic                   emit_last_q;
	logic [TAP_COUNT_W-1:0] tap_count_q;
	logic [SCALE_W-1:0]     scale_q;

	logic                          res_valid_q;
	logic signed [SAMPLE_BITS-1:0] res_q;
	logic                          res_last_q;
	logic                          res_sat_q;

	logic [TW-1:0]  taps_used;
	logic [TW-1:0]  center;
	logic [CW-1:0]  shift_len;
	logic [TW:0]    pend_next;
	logic           emit_now;
	logic [TW-1:0]  pend_kept;
	logic           item_acc;
	logic           sample_acc;
	logic           tap_we;
	logic           out_free;
	logic           out_load;
	cell_ctl_t      cell_ctl;

	logic signed [SAMPLE_BITS-1:0] push_data;
	logic signed [SAMPLE_BITS-1:0] win_c [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] feed_c [MAX_TAPS];
	logic signed [ACC_BITS-1:0]    ps_c [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] scaled;
	logic                          scaled_sat;

	always_comb begin
		if (tap_count_q == '0) begin
			taps_used = TW'(1);
		end else if (tap_count_q > TAP_COUNT_W'(MAX_TAPS)) begin
			taps_used = TW'(MAX_TAPS);
		end else begin
			taps_used = TW'(tap_count_q);
		end
		center    = taps_used >> 1;
		shift_len = CW'(LASTC) - CW'({center, 1'b0});
		pend_next = {1'b0, pending_q} + 1'b1;
		emit_now  = pend_next > {1'b0, center};
		pend_kept = emit_now ? center : pend_next[TW-1:0];
	end

	assign items.ready = (state_q == ST_IDLE);
	assign item_acc    = items.valid && items.ready;
	assign sample_acc  = item_acc && items.action == ACT_SAMPLE;
	assign tap_we      = item_acc && items.action == ACT_LOAD;
	assign out_free    = !res_valid_q || results.ready;
	assign out_load    = (state_q == ST_OUT) && out_free;
	assign push_data   = (state_q == ST_IDLE) ? items.sample : '0;

	always_comb begin
		cell_ctl.push  = sample_acc || (state_q == ST_PUSHZ);
		cell_ctl.clear = out_load && flush_q == '0 && last_q;
		cell_ctl.load  = (state_q == ST_LOAD);
		cell_ctl.shift = (state_q == ST_SHIFT) && cnt_q != '0;
	end

	for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] win_in;
		logic signed [SAMPLE_BITS-1:0] feed_in;
		logic signed [ACC_BITS-1:0]    ps_in;

		if (i == 0) begin : g_head
			assign win_in = push_data;
			assign ps_in  = '0;
		end else begin : g_body
			assign win_in = win_c[i-1];
			assign ps_in  = ps_c[i-1];
		end
		if (i == MAX_TAPS - 1) begin : g_tail
			assign feed_in = '0;
		end else begin : g_next
			assign feed_in = feed_c[i+1];
		end

		fcs_cell #(
			.INDEX       (i),
			.SAMPLE_BITS (SAMPLE_BITS),
			.COEF_BITS   (COEF_BITS),
			.ACC_BITS    (ACC_BITS),
			.TAP_W       (TW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.tap_we    (tap_we),
			.tap_index (items.tap_index),
			.tap_value (items.tap_value),
			.taps_used (taps_used),
			.win_in    (win_in),
			.win_out   (win_c[i]),
			.feed_load (win_c[LASTC-i]),
			.feed_in   (feed_in),
			.feed_out  (feed_c[i]),
			.ps_in     (ps_in),
			.ps_out    (ps_c[i])
		);
	end

	fcs_scaler #(
		.ACC_BITS    (ACC_BITS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_scaler (
		.clk       (clk),
		.acc       (ps_c[MAX_TAPS-1]),
		.scale     (scale_q),
		.result    (scaled),
		.saturated (scaled_sat)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RST;
			scale_q     <= SCALE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TAP_COUNT: tap_count_q <= cfg.data[TAP_COUNT_W-1:0];
				REG_SCALE:     scale_q     <= cfg.data[SCALE_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pending_q   <= '0;
			flush_q     <= '0;
			last_q      <= 1'b0;
			emit_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sample_acc) begin
						pending_q <= pend_kept;
						flush_q   <= items.last ? pend_kept : '0;
						last_q    <= items.last;
						if (emit_now) begin
							emit_last_q <= items.last && center == '0;
							state_q     <= ST_LOAD;
						end else if (items.last) begin
							state_q <= ST_PUSHZ;
						end
					end
				end
				ST_PUSHZ: begin
					emit_last_q <= (flush_q == TW'(1));
					flush_q     <= flush_q - 1'b1;
					state_q     <= ST_LOAD;
				end
				ST_LOAD: begin
					cnt_q   <= shift_len;
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (cnt_q == '0) begin
						cnt_q   <= CW'(MAX_TAPS - 1);
						state_q <= ST_SUM;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SUM: begin
					if (cnt_q == '0) begin
						cnt_q   <= CW'(SCALE_LAT - 1);
						state_q <= ST_SCALE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SCALE: begin
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						if (flush_q != '0) begin
							state_q <= ST_PUSHZ;
						end else begin
							state_q <= ST_IDLE;
							if (last_q) begin
								pending_q <= '0;
								last_q    <= 1'b0;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q      <= scaled;
			res_last_q <= emit_last_q;
			res_sat_q  <= scaled_sat;
		end
	end

	assign results.valid       = res_valid_q;
	assign results.result      = res_q;
	assign results.result_last = res_last_q;
	assign results.saturated   = res_sat_q;

	`ASSERT_IMPLY(a_flush_needs_last, clk, arst_n, flush_q != '0, last_q, "flush count without last transaction")
	`ASSERT_IMPLY(a_out_reg_free, clk, arst_n, out_load, !res_valid_q || results.ready, "output register overwritten")
	`ASSERT_IMPLY(a_sum_quiet, clk, arst_n, state_q == ST_SUM, !(cell_ctl.push || cell_ctl.clear || cell_ctl.load || cell_ctl.shift), "cell data moved during summation")
	`ASSERT_IMPLY(a_pushz_owed, clk, arst_n, state_q == ST_PUSHZ, flush_q != '0, "zero push with no flush owed")

endmodule

@@ hdl/fcs_cell.sv @@
// One filter cell: window sample, kernel tap, feed sample, product and partial sum.
module fcs_cell #(
	parameter int INDEX       = 0,
	parameter int SAMPLE_BITS = fcs_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = fcs_pkg::COEF_BITS_DEF,
	parameter int ACC_BITS    = 48,
	parameter int TAP_W       = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fcs_pkg::cell_ctl_t               ctl,
	input  logic                             tap_we,
	input  logic [fcs_pkg::TAP_IDX_W-1:0]    tap_index,
	input  logic signed [COEF_BITS-1:0]      tap_value,
	input  logic [TAP_W-1:0]                 taps_used,
	input  logic signed [SAMPLE_BITS-1:0]    win_in,
	output logic signed [SAMPLE_BITS-1:0]    win_out,
	input  logic signed [SAMPLE_BITS-1:0]    feed_load,
	input  logic signed [SAMPLE_BITS-1:0]    feed_in,
	output logic signed [SAMPLE_BITS-1:0]    feed_out,
	input  logic signed [ACC_BITS-1:0]       ps_in,
	output logic signed [ACC_BITS-1:0]       ps_out
);
	import fcs_pkg::*;

	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;

	logic signed [SAMPLE_BITS-1:0] win_q;
	logic signed [SAMPLE_BITS-1:0] feed_q;
	logic signed [COEF_BITS-1:0]   tap_q;
	logic signed [PROD_BITS-1:0]   prod_c;
	logic signed [PROD_BITS-1:0]   prod_q;
	logic signed [ACC_BITS-1:0]    ps_q;
	logic                          tap_active;

	assign prod_c     = tap_q * feed_q;
	assign tap_active = TAP_W'(INDEX) < taps_used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			tap_q <= '0;
		end else begin
			if (ctl.clear) begin
				win_q <= '0;
			end else if (ctl.push) begin
				win_q <= win_in;
			end
			if (tap_we && tap_index == TAP_IDX_W'(INDEX)) begin
				tap_q <= tap_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			feed_q <= feed_load;
		end else if (ctl.shift) begin
			feed_q <= feed_in;
		end
		prod_q <= tap_active ? prod_c : '0;
		ps_q   <= ps_in + ACC_BITS'(prod_q);
	end

	assign win_out  = win_q;
	assign feed_out = feed_q;
	assign ps_out   = ps_q;

endmodule

@@ hdl/fcs_scaler.sv @@
// Gain stage: exact sum times Q8.8 scale, floor shift and saturation.
module fcs_scaler #(
	parameter int ACC_BITS    = 48,
	parameter int SAMPLE_BITS = fcs_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = fcs_pkg::COEF_BITS_DEF
) (
	input  logic                          clk,
	input  logic signed [ACC_BITS-1:0]    acc,
	input  logic [fcs_pkg::SCALE_W-1:0]   scale,
	output logic signed [SAMPLE_BITS-1:0] result,
	output logic                          saturated
);
	import fcs_pkg::*;

	localparam int LO_BITS      = ACC_BITS / 2;
	localparam int HI_BITS      = ACC_BITS - LO_BITS;
	localparam int LO_PROD_BITS = LO_BITS + SCALE_W;
	localparam int HI_PROD_BITS = HI_BITS + SCALE_W + 1;
	localparam int FULL_BITS    = ACC_BITS + SCALE_W + 1;
	localparam int FRAC_BITS    = COEF_BITS - 1 + SCALE_FRAC_W;

	logic [LO_PROD_BITS-1:0]        lo_prod_s1;
	logic signed [HI_PROD_BITS-1:0] hi_prod_s1;
	logic signed [FULL_BITS-1:0]    full_s2;
	logic signed [FULL_BITS-1:0]    shifted;
	logic                           fits;
	logic signed [SAMPLE_BITS-1:0]  result_s3;
	logic                           sat_s3;

	assign shifted = full_s2 >>> FRAC_BITS;
	assign fits    = (&shifted[FULL_BITS-1:SAMPLE_BITS-1]) | ~(|shifted[FULL_BITS-1:SAMPLE_BITS-1]);

	always_ff @(posedge clk) begin
		lo_prod_s1 <= LO_PROD_BITS'(acc[LO_BITS-1:0]) * LO_PROD_BITS'(scale);
		hi_prod_s1 <= $signed(acc[ACC_BITS-1:LO_BITS]) * $signed({1'b0, scale});
		full_s2    <= (FULL_BITS'(hi_prod_s1) <<< LO_BITS) + $signed(FULL_BITS'(lo_prod_s1));
		if (fits) begin
			result_s3 <= shifted[SAMPLE_BITS-1:0];
		end else if (shifted[FULL_BITS-1]) begin
			result_s3 <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			result_s3 <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		sat_s3 <= ~fits;
	end

	assign result    = result_s3;
	assign saturated = sat_s3;

endmodule
